@@ rtl/scr_pkg.sv @@
// ----------------------------------------------------------------------------
// Style cascade resolver package
// Request and result types, request kinds and the selector table entry type.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Request kinds. Codes six and seven carry no meaning.
  localparam logic [2:0] KIND_ADD     = 3'd0;
  localparam logic [2:0] KIND_REMOVE  = 3'd1;
  localparam logic [2:0] KIND_CLEAR   = 3'd2;
  localparam logic [2:0] KIND_SET     = 3'd3;
  localparam logic [2:0] KIND_UNSET   = 3'd4;
  localparam logic [2:0] KIND_RESOLVE = 3'd5;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  style_slot;
    logic [7:0]  part_code;
    logic [15:0] state_mask;
    logic [5:0]  property_id;
    logic [31:0] property_value;
  } req_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic        status;
    logic        found;
    logic [31:0] resolved_value;
    logic [4:0]  specificity;
  } rsp_t;

  // One selector table entry.
  typedef struct packed {
    logic [2:0]  style;
    logic [7:0]  part;
    logic [15:0] mask;
  } entry_t;

endpackage

@@ rtl/scr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module scr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/style_cascade_resolver.sv @@
// ----------------------------------------------------------------------------
// Style cascade resolver
// Ordered selector table with a property store per style slot.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. Each
// request gives exactly one result, shown on result for one cycle with done
// high; the receiver cannot hold results off, and the output register lets a
// new request be taken in the same cycle as a result is shown.
// Add, clear table, set property, clear property and unknown kinds never raise
// busy: the result follows on the next cycle.
// Remove walks the table memory one entry a cycle and compacts it in place.
// Resolve streams the table through a three-stage chain (table read, property
// store read, compare). With an empty table both give their result on the
// next cycle without raising busy. The single read port of the table memory
// sets the pace of the walk and the scan.
// After reset the block sweeps the STYLE_SLOTS * PROP_COUNT property store
// entries (512 by default), clearing every valid bit; busy is high meanwhile.
// ----------------------------------------------------------------------------
module style_cascade_resolver
  import scr_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int STYLE_SLOTS = 8,
  parameter int PROP_COUNT  = 64,
  parameter int VALUE_BITS  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int TW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW          = $clog2(MAX_ENTRIES + 1);
  localparam int STORE_DEPTH = STYLE_SLOTS * PROP_COUNT;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW          = VALUE_BITS + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  // Store address of a style slot and property.
  function automatic logic [AW-1:0] store_addr(input logic [2:0] slot,
                                               input logic [5:0] prop);
    logic [31:0] full;
    full = 32'(slot) * 32'(PROP_COUNT) + 32'(prop);
    return full[AW-1:0];
  endfunction

  // True when both slot and property lie inside the store.
  function automatic logic store_ok(input logic [2:0] slot, input logic [5:0] prop);
    return (32'(slot) < 32'(STYLE_SLOTS)) && (32'(prop) < 32'(PROP_COUNT));
  endfunction

  // Number of set bits in a state mask.
  function automatic logic [4:0] bit_count(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

  state_t          state;
  logic [CW-1:0]   count;
  logic [AW-1:0]   clr_addr;
  req_t            cur;
  logic [CW-1:0]   rd_idx;
  logic [CW-1:0]   wr_ptr;
  logic            a_valid;
  logic            a_last;
  logic            b_valid;
  logic            b_last;
  logic [4:0]      b_pc;
  logic            best_found;
  logic [4:0]      best_pc;
  logic [VALUE_BITS-1:0] best_val;

  logic            t_we;
  logic [TW-1:0]   t_waddr;
  entry_t          t_wdata;
  entry_t          t_rdata;
  logic            p_we;
  logic [AW-1:0]   p_waddr;
  logic [PW-1:0]   p_wdata;
  logic [AW-1:0]   p_raddr;
  logic [PW-1:0]   p_rdata;

  logic            accept;
  logic            full;
  logic            issue;
  logic            issue_last;
  logic            keep;
  logic            hit;
  logic            win;
  logic            fin_found;
  logic [4:0]      fin_pc;
  logic [VALUE_BITS-1:0] fin_val;
  logic [63:0]     in_val64;
  logic [63:0]     fin_val64;
  logic [AW-1:0]   req_addr;
  logic            req_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count >= CW'(MAX_ENTRIES));

  // Table read issue: one entry a cycle while walking or scanning.
  assign issue      = ((state == S_WALK) || (state == S_SCAN)) && (rd_idx < count);
  assign issue_last = (rd_idx == count - CW'(1));

  // Entry returned by the table memory, checked against the request.
  assign keep = !((t_rdata.style == cur.style_slot) && (t_rdata.part == cur.part_code) &&
                  (t_rdata.mask == cur.state_mask));
  assign hit  = (t_rdata.part == cur.part_code) &&
                ((t_rdata.mask & cur.state_mask) == t_rdata.mask) &&
                store_ok(t_rdata.style, cur.property_id);
  assign p_raddr = store_addr(t_rdata.style, cur.property_id);

  // Compare stage: a later entry of equal specificity replaces the winner.
  assign win       = b_valid && p_rdata[VALUE_BITS] && (!best_found || (b_pc >= best_pc));
  assign fin_found = best_found || win;
  assign fin_pc    = win ? b_pc : best_pc;
  assign fin_val   = win ? p_rdata[VALUE_BITS-1:0] : best_val;
  assign fin_val64 = 64'(fin_val);

  assign in_val64 = 64'(request.property_value);
  assign req_addr = store_addr(request.style_slot, request.property_id);
  assign req_ok   = store_ok(request.style_slot, request.property_id);

  // Write ports of both memories.
  always_comb begin
    t_we    = 1'b0;
    t_waddr = count[TW-1:0];
    t_wdata = '{style: request.style_slot, part: request.part_code,
                mask: request.state_mask};
    p_we    = 1'b0;
    p_waddr = clr_addr;
    p_wdata = '0;
    case (state)
      S_CLEAR: begin
        p_we = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          case (request.kind)
            KIND_ADD: begin
              t_we = !full;
            end
            KIND_SET: begin
              p_we    = req_ok;
              p_waddr = req_addr;
              p_wdata = {1'b1, in_val64[VALUE_BITS-1:0]};
            end
            KIND_UNSET: begin
              p_we    = req_ok;
              p_waddr = req_addr;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        t_we    = a_valid && keep;
        t_waddr = wr_ptr[TW-1:0];
        t_wdata = t_rdata;
      end
      default: begin
      end
    endcase
  end

  scr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES),
    .AW    (TW)
  ) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (rd_idx[TW-1:0]),
    .rdata (t_rdata)
  );

  scr_ram #(
    .WIDTH (PW),
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // Sequencer, pipeline stages and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      count    <= '0;
      clr_addr <= '0;
      rd_idx   <= '0;
      wr_ptr   <= '0;
      a_valid  <= 1'b0;
      a_last   <= 1'b0;
      b_valid  <= 1'b0;
      b_last   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done    <= 1'b0;
      a_valid <= issue;
      a_last  <= issue && issue_last;
      b_valid <= (state == S_SCAN) && a_valid && hit;
      b_last  <= (state == S_SCAN) && a_valid && a_last;
      b_pc    <= bit_count(t_rdata.mask);
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(STORE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur        <= request;
            result     <= '0;
            best_found <= 1'b0;
            best_pc    <= '0;
            best_val   <= '0;
            rd_idx     <= '0;
            wr_ptr     <= '0;
            case (request.kind)
              KIND_ADD: begin
                done <= 1'b1;
                if (full) begin
                  result.status <= 1'b1;
                end else begin
                  count <= count + CW'(1);
                end
              end
              KIND_REMOVE: begin
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_WALK;
                end
              end
              KIND_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              KIND_RESOLVE: begin
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          if (a_valid && keep) begin
            wr_ptr <= wr_ptr + CW'(1);
          end
          if (a_valid && a_last) begin
            count  <= wr_ptr + CW'(keep);
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= '0;
          end
        end
        S_SCAN: begin
          if (win) begin
            best_found <= 1'b1;
            best_pc    <= b_pc;
            best_val   <= p_rdata[VALUE_BITS-1:0];
          end
          if (b_last) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= '{status: 1'b0, found: fin_found,
                        resolved_value: fin_val64[31:0], specificity: fin_pc};
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/scr_checker.sv @@
// ----------------------------------------------------------------------------
// Style cascade resolver checker
// Port-level assertions on reset behaviour, busy and result contents.
// ----------------------------------------------------------------------------
module scr_checker
  import scr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // The store sweep after reset keeps the block busy and silent.
  a_busy_after_reset: assert property (@(posedge clk)
    $past(rst) |-> busy && !done)
    else $error("block not busy or gave a result straight after reset");

  // Busy rises only because a request was taken.
  a_busy_needs_request: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(busy) && !$past(start) |-> !busy)
    else $error("busy rose without a request");

  // A dropped add never reports a resolve hit.
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    done && result.status |-> !result.found)
    else $error("overflow status together with a resolve hit");

  // Nothing found means zero value and zero specificity.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> (result.resolved_value == '0) && (result.specificity == '0))
    else $error("result fields not zero without a hit");

  // A state mask has at most sixteen bits set.
  a_spec_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.specificity <= 5'd16)
    else $error("specificity beyond sixteen");

endmodule

bind style_cascade_resolver scr_checker u_scr_checker (.*);
